// ----- hw/rtl/pctagg_pkg.sv -----
// shared types and constants of the per-cell temporal aggregator
`timescale 1ns / 1ps
package pctagg_pkg;

  // default sizes
  localparam int unsigned MaxCellsDef   = 4096;
  localparam int unsigned ValueWidthDef = 32;

  // register and field widths
  localparam int unsigned ModeW    = 3;
  localparam int unsigned CountW   = 13;
  localparam int unsigned FrameW   = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CountW-1:0] CountRst = CountW'(4096);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegAggMode   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegCellCount = CfgIdxW'(1);

  // aggregation modes
  typedef enum logic [ModeW-1:0] {
    MODE_NONE = 3'd0,
    MODE_SUM  = 3'd1,
    MODE_AVG  = 3'd2,
    MODE_MIN  = 3'd3,
    MODE_MAX  = 3'd4
  } agg_mode_e;

  // operation the back end performs on one cell
  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_LOAD = 3'd1,
    OP_SUM  = 3'd2,
    OP_AVG  = 3'd3,
    OP_MIN  = 3'd4,
    OP_MAX  = 3'd5
  } op_e;

  // control travelling with each queued item
  typedef struct packed {
    op_e  op;
    logic last;
  } ctrl_t;

  // back end sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_ADD  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } bstate_e;

endpackage

// ----- hw/rtl/per_cell_temporal_aggregator.sv -----
// top level of the per-cell temporal aggregator
`timescale 1ns / 1ps
// Keeps one aggregate per raster cell across frames (sum with saturation,
// truncated running average, minimum or maximum, chosen by agg_mode) and
// returns the updated aggregate of each cell as it streams in, in cell order
// (mode none returns the stored value unchanged). In the other modes the first
// frame loads samples directly. Samples are accepted into a two-entry queue
// while the back end works, so input and output stall independently. The back
// end takes one item at a time: a registered cell store read, then a combine
// and write back; in average mode after the first frame a multiply, the
// numerator and the bit-serial divider (one quotient bit a cycle) lie between.
// The cell store has no reset; a cell is defined once the first frame wrote it.
module per_cell_temporal_aggregator #(
  parameter int unsigned MAX_CELLS   = pctagg_pkg::MaxCellsDef,
  parameter int unsigned VALUE_WIDTH = pctagg_pkg::ValueWidthDef,
  localparam int unsigned IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
  localparam int unsigned IN_W  = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_F = IDX_W + VALUE_WIDTH + pctagg_pkg::FrameW,
  localparam int unsigned OUT_W = ((OUT_F + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pctagg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pctagg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,  // sample
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_W-1:0]                m_axis_tdata,  // cell_index, aggregate, frames_seen
  output logic                            m_axis_tlast
);

  localparam int unsigned CTW = $bits(pctagg_pkg::ctrl_t);
  localparam int unsigned QW  = VALUE_WIDTH + pctagg_pkg::FrameW + IDX_W + CTW;

  pctagg_pkg::ctrl_t               f_ctrl, b_ctrl;
  logic [IDX_W-1:0]                f_idx, b_idx, o_idx;
  logic [pctagg_pkg::FrameW-1:0]   f_fc, b_fc, o_fc;
  logic [VALUE_WIDTH-1:0]          b_x, o_agg;
  logic [QW-1:0]                   q_in, q_out;
  logic                            accept, q_full, q_valid, q_pop;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // front end
  pctagg_front #(
    .MAX_CELLS (MAX_CELLS),
    .IDX_W     (IDX_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .ctrl_o      (f_ctrl),
    .idx_o       (f_idx),
    .frames_o    (f_fc)
  );

  assign q_in = {s_axis_tdata[VALUE_WIDTH-1:0], f_fc, f_idx, f_ctrl};

  // queue
  pctagg_fifo #(
    .W (QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {b_x, b_fc, b_idx, b_ctrl} = q_out;

  // back end
  pctagg_back #(
    .MAX_CELLS   (MAX_CELLS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .q_ctrl_i     (b_ctrl),
    .q_idx_i      (b_idx),
    .q_frames_i   (b_fc),
    .q_sample_i   (b_x),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_idx_o    (o_idx),
    .out_agg_o    (o_agg),
    .out_frames_o (o_fc),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_W'({o_fc, o_agg, o_idx});

endmodule

// ----- hw/rtl/pctagg_front.sv -----
// front end: config registers, cell pointer, frame counter, item classification
`timescale 1ns / 1ps
module pctagg_front #(
  parameter int unsigned MAX_CELLS = pctagg_pkg::MaxCellsDef,
  parameter int unsigned IDX_W     = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [pctagg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pctagg_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                            accept_i,
  output pctagg_pkg::ctrl_t               ctrl_o,
  output logic [IDX_W-1:0]                idx_o,
  output logic [pctagg_pkg::FrameW-1:0]   frames_o
);

  localparam int unsigned CW = (IDX_W + 1 > pctagg_pkg::CountW) ? IDX_W + 1
                                                                 : pctagg_pkg::CountW;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_CELLS);

  logic [pctagg_pkg::ModeW-1:0]  mode_q;
  logic [pctagg_pkg::CountW-1:0] count_q;
  logic [IDX_W-1:0]              ptr_q, ptr_d;
  logic [pctagg_pkg::FrameW-1:0] fc_q, fc_d;
  logic [CW-1:0]                 cnt_eff, next_pos;
  logic                          last;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pctagg_pkg::ModeW'(pctagg_pkg::MODE_NONE);
      count_q <= pctagg_pkg::CountRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == pctagg_pkg::RegAggMode) begin
        mode_q <= cfg_data_i[pctagg_pkg::ModeW-1:0];
      end else if (cfg_index_i == pctagg_pkg::RegCellCount) begin
        count_q <= cfg_data_i[pctagg_pkg::CountW-1:0];
      end
    end
  end

  // effective count and end of frame
  always_comb begin
    cnt_eff = CW'(count_q);
    if (count_q == '0) begin
      cnt_eff = CW'(1);
    end else if (cnt_eff > MaxCnt) begin
      cnt_eff = MaxCnt;
    end
    next_pos = CW'(ptr_q) + CW'(1);
    last     = (next_pos >= cnt_eff);
  end

  // classify the item
  always_comb begin
    ctrl_o.last = last;
    case (mode_q)
      pctagg_pkg::MODE_SUM: ctrl_o.op = pctagg_pkg::OP_SUM;
      pctagg_pkg::MODE_AVG: ctrl_o.op = pctagg_pkg::OP_AVG;
      pctagg_pkg::MODE_MIN: ctrl_o.op = pctagg_pkg::OP_MIN;
      pctagg_pkg::MODE_MAX: ctrl_o.op = pctagg_pkg::OP_MAX;
      default:              ctrl_o.op = pctagg_pkg::OP_NONE;
    endcase
    if (ctrl_o.op != pctagg_pkg::OP_NONE && fc_q == '0) begin
      ctrl_o.op = pctagg_pkg::OP_LOAD;
    end
  end

  assign idx_o    = ptr_q;
  assign frames_o = fc_q;

  // pointer and frame counter advance
  always_comb begin
    ptr_d = ptr_q;
    fc_d  = fc_q;
    if (accept_i) begin
      if (last) begin
        ptr_d = '0;
        if (fc_q != '1) begin
          fc_d = fc_q + 1'b1;
        end
      end else begin
        ptr_d = next_pos[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      fc_q  <= '0;
    end else begin
      ptr_q <= ptr_d;
      fc_q  <= fc_d;
    end
  end

endmodule

// ----- hw/rtl/pctagg_fifo.sv -----
// two-entry queue between front and back end
`timescale 1ns / 1ps
module pctagg_fifo #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] slot_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = slot_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ----- hw/rtl/pctagg_back.sv -----
// back end: cell store, combine unit, serial divider and output register
`timescale 1ns / 1ps
module pctagg_back #(
  parameter int unsigned MAX_CELLS   = pctagg_pkg::MaxCellsDef,
  parameter int unsigned VALUE_WIDTH = pctagg_pkg::ValueWidthDef,
  parameter int unsigned IDX_W       = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  pctagg_pkg::ctrl_t             q_ctrl_i,
  input  logic [IDX_W-1:0]              q_idx_i,
  input  logic [pctagg_pkg::FrameW-1:0] q_frames_i,
  input  logic [VALUE_WIDTH-1:0]        q_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [IDX_W-1:0]              out_idx_o,
  output logic [VALUE_WIDTH-1:0]        out_agg_o,
  output logic [pctagg_pkg::FrameW-1:0] out_frames_o,
  output logic                          out_last_o
);

  localparam int unsigned VW  = VALUE_WIDTH;
  localparam int unsigned FW  = pctagg_pkg::FrameW;
  localparam int unsigned MW  = VW + FW + 1;
  localparam int unsigned NW  = VW + FW + 2;
  localparam int unsigned DW  = FW + 2;
  localparam int unsigned ICW = $clog2(NW + 1);

  logic [VW-1:0] mem [MAX_CELLS];

  pctagg_pkg::bstate_e state_q, state_d;
  pctagg_pkg::ctrl_t   ctrl_q;
  logic [IDX_W-1:0]    idx_q;
  logic [FW-1:0]       fc_q;
  logic [VW-1:0]       x_q, rd_q, res;
  logic signed [MW-1:0] mul_q;
  logic [NW-1:0]       mag_q;
  logic [DW-1:0]       rem_q, dsr_q, rem_sh;
  logic [ICW-1:0]      it_q;
  logic                neg_q;
  logic signed [VW:0]  sum;
  logic signed [NW-1:0] num;
  logic                slot_free, fin, pop, we;

  assign slot_free = !out_valid_o || out_ready_i;
  assign pop       = (state_q == pctagg_pkg::S_IDLE) && q_valid_i;
  assign q_pop_o   = pop;
  assign fin = slot_free && ((state_q == pctagg_pkg::S_FIN) ||
               (state_q == pctagg_pkg::S_EXEC && ctrl_q.op != pctagg_pkg::OP_AVG));
  assign we  = fin && (ctrl_q.op != pctagg_pkg::OP_NONE);

  // cell store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[idx_q] <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_q <= mem[q_idx_i];
    end
  end

  // combine stored value with sample
  always_comb begin
    sum = $signed({rd_q[VW-1], rd_q}) + $signed({x_q[VW-1], x_q});
    res = rd_q;
    case (ctrl_q.op)
      pctagg_pkg::OP_LOAD: res = x_q;
      pctagg_pkg::OP_SUM: begin
        if (sum[VW] != sum[VW-1]) begin
          res = sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
          res = sum[VW-1:0];
        end
      end
      pctagg_pkg::OP_MIN: res = ($signed(x_q) < $signed(rd_q)) ? x_q : rd_q;
      pctagg_pkg::OP_MAX: res = ($signed(x_q) > $signed(rd_q)) ? x_q : rd_q;
      pctagg_pkg::OP_AVG: res = neg_q ? VW'(~mag_q + 1'b1) : mag_q[VW-1:0];
      default:            res = rd_q;
    endcase
  end

  // numerator of the average and divider step
  assign num    = NW'(mul_q) + NW'($signed(x_q));
  assign rem_sh = {rem_q[DW-2:0], mag_q[NW-1]};

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      pctagg_pkg::S_IDLE: if (q_valid_i) state_d = pctagg_pkg::S_EXEC;
      pctagg_pkg::S_EXEC: begin
        if (ctrl_q.op == pctagg_pkg::OP_AVG) state_d = pctagg_pkg::S_ADD;
        else if (slot_free)                  state_d = pctagg_pkg::S_IDLE;
      end
      pctagg_pkg::S_ADD:  state_d = pctagg_pkg::S_DIV;
      pctagg_pkg::S_DIV:  if (it_q == ICW'(1)) state_d = pctagg_pkg::S_FIN;
      pctagg_pkg::S_FIN:  if (slot_free) state_d = pctagg_pkg::S_IDLE;
      default:            state_d = pctagg_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pctagg_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // item and datapath registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      ctrl_q <= q_ctrl_i;
      idx_q  <= q_idx_i;
      fc_q   <= q_frames_i;
      x_q    <= q_sample_i;
    end
    if (state_q == pctagg_pkg::S_EXEC) begin
      mul_q <= $signed(rd_q) * $signed({1'b0, fc_q});
    end
    if (state_q == pctagg_pkg::S_ADD) begin
      neg_q <= num[NW-1];
      mag_q <= num[NW-1] ? NW'(-num) : NW'(num);
      rem_q <= '0;
      dsr_q <= DW'(fc_q) + DW'(1);
      it_q  <= ICW'(NW);
    end
    if (state_q == pctagg_pkg::S_DIV) begin
      it_q <= it_q - 1'b1;
      if (rem_sh >= dsr_q) begin
        rem_q <= rem_sh - dsr_q;
        mag_q <= {mag_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        mag_q <= {mag_q[NW-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (fin) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      out_idx_o    <= idx_q;
      out_agg_o    <= res;
      out_frames_o <= fc_q;
      out_last_o   <= ctrl_q.last;
    end
  end

endmodule
